@@ rtl/core/ems_pkg.sv @@
// Package for the envelope macro sequencer core: sizes, codes and payload types.
// Used by envelope_macro_sequencer_core and its bound checker; depends on nothing.
package ems_pkg;

  localparam int SEQ_COUNT  = 5;
  localparam int MAX_ITEMS  = 256;
  localparam int SEQ_W      = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int ITEM_DEPTH = SEQ_COUNT * MAX_ITEMS;
  localparam int ITEM_AW    = $clog2(ITEM_DEPTH);

  localparam logic [7:0] NO_POINT = 8'hFF;
  localparam logic [7:0] END_POSITION = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LOAD    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_LENGTHS  = 2'd1,
    REG_LOOPS    = 2'd2,
    REG_RELEASES = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_DISABLED = 2'd0,
    PH_RUNNING  = 2'd1,
    PH_END      = 2'd2,
    PH_HALT     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_RESULT,
    S_FLUSH
  } fsm_t;

  typedef struct packed {
    kind_t             kind;
    logic              channel_active;
    logic              channel_releasing;
    logic [2:0]        load_sequence;
    logic [7:0]        load_position;
    logic signed [7:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        sequence_index;
    logic              event_res;
    logic signed [7:0] item_value;
    logic [7:0]        play_position;
    logic              last;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] pointer;
  } seq_state_t;

endpackage

@@ rtl/core/envelope_macro_sequencer_core.sv @@
// Top level of the envelope macro sequencer: state memory, item memory and scan control.
// Depends on ems_pkg for sizes, codes and payload types.
//
//   channel | signals                              | a transfer happens when
//   --------+--------------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data          | in_valid high, in_stall low
//   output  | out_valid, out_stall, out_data       | out_valid high, out_stall low
//   config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid high, cfg_ready high
//
// A load writes the item memory in its own cycle; loads stream at one per cycle while idle.
// Tick, trigger and release walk the sequences one at a time through the state memory,
// each in three steps (read, modify and write back, result), then a flush step sends the
// final result. A tick on an inactive channel or a release while already releasing
// needs no scan and leaves the block idle.
// Reset is synchronous; it clears the control state and the valid bits of the state memory.
// A stalled output holds the scan only when the held result must take the output register.
module envelope_macro_sequencer_core
  import ems_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [39:0] cfg_data
);

  // Configuration registers. The user must see that they are only written while the block is idle; it does not check.
  logic [4:0]  enable_mask;
  logic [39:0] lengths;
  logic [39:0] loop_points;
  logic [39:0] release_points;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= '0;
      lengths        <= '0;
      loop_points    <= '1;
      release_points <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:   enable_mask    <= cfg_data[4:0];
        REG_LENGTHS:  lengths        <= cfg_data;
        REG_LOOPS:    loop_points    <= cfg_data;
        REG_RELEASES: release_points <= cfg_data;
        default:      enable_mask    <= enable_mask;
      endcase
    end
  end

  // Per-sequence view of the packed registers. Bytes past the 40-bit registers read as zero.
  logic [63:0]          len_ext, loop_ext, rel_ext;
  logic [7:0]           en_ext;
  logic [SEQ_COUNT-1:0] seq_en;
  logic [7:0]           len_byte  [SEQ_COUNT];
  logic [7:0]           loop_byte [SEQ_COUNT];
  logic [7:0]           rel_byte  [SEQ_COUNT];

  always_comb begin
    len_ext  = 64'(lengths);
    loop_ext = 64'(loop_points);
    rel_ext  = 64'(release_points);
    en_ext   = 8'(enable_mask);
    for (int i = 0; i < SEQ_COUNT; i++) begin
      seq_en[i]    = en_ext[i];
      len_byte[i]  = len_ext[8*i +: 8];
      loop_byte[i] = loop_ext[8*i +: 8];
      rel_byte[i]  = rel_ext[8*i +: 8];
    end
  end

  // Control registers.
  fsm_t             state, state_next;
  logic [SEQ_W-1:0] seq_idx;
  kind_t            cur_kind;
  logic             cur_releasing;

  // Result pending from the modify step, and the item memory read that goes with it.
  logic       r_gen;
  logic       r_end;
  logic [7:0] r_pos;
  logic       r_item_ok;

  // One result is held back until the scan knows whether another follows it,
  // so that the final result of a tick can carry last.
  logic      pend_valid;
  out_item_t pend;
  out_item_t out_data_next;

  // Handshake and control decisions.
  logic accept, scan_start, last_seq, out_free;
  logic push_pend, move_out, move_last, advance, ex_step;

  assign accept   = in_valid && !in_stall;
  assign last_seq = (32'(seq_idx) == SEQ_COUNT - 1);
  assign out_free = !out_valid || !out_stall;

  // Tick on an active channel, trigger, and release outside the release phase need a scan.
  always_comb begin
    case (in_data.kind)
      KIND_TICK:    scan_start = in_data.channel_active;
      KIND_TRIGGER: scan_start = 1'b1;
      KIND_RELEASE: scan_start = !in_data.channel_releasing;
      default:      scan_start = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept && scan_start) state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC:   state_next = S_RESULT;
      S_RESULT: begin
        if (!r_gen || !pend_valid || out_free) state_next = last_seq ? S_FLUSH : S_READ;
      end
      S_FLUSH:  if (!pend_valid || out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_stall  = (state != S_IDLE);
    ex_step   = (state == S_EXEC);
    push_pend = (state == S_RESULT) && r_gen && (!pend_valid || out_free);
    move_out  = ((state == S_RESULT) && r_gen && pend_valid && out_free) ||
                ((state == S_FLUSH) && pend_valid && out_free);
    move_last = (state == S_FLUSH);
    advance   = (state == S_RESULT) && (!r_gen || !pend_valid || out_free) && !last_seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && scan_start) begin
      seq_idx       <= '0;
      cur_kind      <= in_data.kind;
      cur_releasing <= in_data.channel_releasing;
    end else if (advance) begin
      seq_idx <= seq_idx + 1'b1;
    end
  end

  // State memory: phase and play pointer per sequence, synchronous read. An entry whose
  // valid bit is clear reads as disabled with pointer zero. The read used by the modify step
  // precedes the write-back of the same sequence, since the scan handles them in turn.
  seq_state_t           state_mem [SEQ_COUNT];
  logic [SEQ_COUNT-1:0] st_valid;
  seq_state_t           st_rd;
  logic                 st_rd_ok;
  logic                 st_we;
  seq_state_t           st_wdata;
  seq_state_t           cur_st;

  always_ff @(posedge clk) begin
    if (st_we) state_mem[seq_idx] <= st_wdata;
    st_rd    <= state_mem[seq_idx];
    st_rd_ok <= st_valid[seq_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (st_we) begin
      st_valid[seq_idx] <= 1'b1;
    end
  end

  assign cur_st = st_rd_ok ? st_rd : seq_state_t'{phase: PH_DISABLED, pointer: 8'd0};

  // Modify step. Loop and release points of 255 act as -1, so the arithmetic is signed.
  logic              present, has_items, loop_none, rel_none, wrap, to_end;
  logic signed [9:0] p_s, p_new, rel_s, loop_s, items_s;
  logic              gen, gen_end;

  always_comb begin
    present   = seq_en[seq_idx];
    has_items = (len_byte[seq_idx] != 8'd0);
    loop_none = (loop_byte[seq_idx] == NO_POINT);
    rel_none  = (rel_byte[seq_idx] == NO_POINT);
    rel_s     = rel_none ? -10'sd1 : $signed({2'b00, rel_byte[seq_idx]});
    loop_s    = loop_none ? -10'sd1 : $signed({2'b00, loop_byte[seq_idx]});
    items_s   = $signed({2'b00, len_byte[seq_idx]});
    p_s       = $signed({2'b00, cur_st.pointer}) + 10'sd1;
    p_new     = p_s;
    to_end    = 1'b0;
    wrap      = (p_s == rel_s + 10'sd1) || (p_s >= items_s);
    if (wrap) begin
      if (!loop_none && !(cur_releasing && !rel_none) && (loop_s < rel_s)) begin
        p_new = loop_s;
      end else if (p_s >= items_s) begin
        if ((loop_s >= rel_s) && !loop_none) begin
          p_new = loop_s;
        end else begin
          to_end = 1'b1;
        end
      end else if (!cur_releasing) begin
        // Hold at the release point until the note is released.
        p_new = p_s - 10'sd1;
      end
    end

    st_we    = 1'b0;
    st_wdata = cur_st;
    gen      = 1'b0;
    gen_end  = 1'b0;
    case (cur_kind)
      KIND_TICK: begin
        if (present && has_items) begin
          if (cur_st.phase == PH_RUNNING) begin
            st_we    = ex_step;
            st_wdata = '{phase: (to_end ? PH_END : PH_RUNNING), pointer: p_new[7:0]};
            gen      = 1'b1;
          end else if (cur_st.phase == PH_END) begin
            st_we    = ex_step;
            st_wdata = '{phase: PH_HALT, pointer: cur_st.pointer};
            gen      = 1'b1;
            gen_end  = 1'b1;
          end
        end
      end
      KIND_TRIGGER: begin
        if (present) begin
          st_we    = ex_step;
          st_wdata = '{phase: PH_RUNNING, pointer: 8'd0};
        end
      end
      KIND_RELEASE: begin
        if (present && !rel_none &&
            (cur_st.phase == PH_RUNNING || cur_st.phase == PH_END)) begin
          st_we    = ex_step;
          st_wdata = '{phase: PH_RUNNING, pointer: rel_byte[seq_idx]};
        end
      end
      default: st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ex_step) begin
      r_gen     <= gen;
      r_end     <= gen_end;
      r_pos     <= gen_end ? END_POSITION : p_new[7:0];
      r_item_ok <= (32'(cur_st.pointer) < MAX_ITEMS);
    end
  end

  // Item memory: one table of MAX_ITEMS entries per sequence. Loads write it while idle;
  // the modify step reads the entry at the current pointer.
  logic signed [7:0] item_mem [ITEM_DEPTH];
  logic signed [7:0] item_rd;
  logic              load_we;
  logic [ITEM_AW-1:0] load_addr, read_addr;

  assign load_we = accept && (in_data.kind == KIND_LOAD) &&
                   (32'(in_data.load_sequence) < SEQ_COUNT) &&
                   (32'(in_data.load_position) < MAX_ITEMS);
  assign load_addr = ITEM_AW'(in_data.load_sequence) * ITEM_AW'(MAX_ITEMS) +
                     ITEM_AW'(in_data.load_position);
  assign read_addr = ITEM_AW'(seq_idx) * ITEM_AW'(MAX_ITEMS) + ITEM_AW'(cur_st.pointer);

  always_ff @(posedge clk) begin
    if (load_we) item_mem[load_addr] <= in_data.load_value;
    if (ex_step) item_rd <= item_mem[read_addr];
  end

  // Held result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (push_pend) begin
      pend_valid <= 1'b1;
    end else if (move_out) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      pend <= '{sequence_index: 3'(seq_idx),
                event_res:      r_end,
                item_value:     (r_end || !r_item_ok) ? 8'sd0 : item_rd,
                play_position:  r_pos,
                last:           1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The flush step marks the result it sends as the final one of the tick.
  always_comb begin
    out_data_next      = pend;
    out_data_next.last = move_last;
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_data <= out_data_next;
    end
  end

endmodule

@@ rtl/core/ems_checker.sv @@
// Port-level checker for envelope_macro_sequencer_core, bound to every instance.
// Depends on ems_pkg for the payload types and codes.
module ems_checker
  import ems_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Nothing leaves the block in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // Every result names a sequence that exists.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.sequence_index) < SEQ_COUNT)
    else $error("result for a sequence that does not exist");

  // An end marker carries a zero item and the end position.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res |->
      out_data.item_value == 8'sd0 && out_data.play_position == END_POSITION)
    else $error("end marker with item or position");

  // An event that walks the sequences blocks the input in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    ((in_data.kind == KIND_TICK && in_data.channel_active) ||
     in_data.kind == KIND_TRIGGER ||
     (in_data.kind == KIND_RELEASE && !in_data.channel_releasing)) |=> in_stall)
    else $error("input taken while a scan is running");

endmodule

bind envelope_macro_sequencer_core ems_checker u_ems_checker (.*);
